// File: rtl/frs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_pkg: shared types and constants of the fitness roulette selector
// Operation codes, item structs, controller states and fixed field widths.
// ----------------------------------------------------------------------------
package frs_pkg;

   localparam int FIT_W       = 32;  // fitness, Q16.16
   localparam int SUM_W       = 40;  // saturated stats sum
   localparam int IND_W       = 41;  // select indicator
   localparam int POP_SIZE_W  = 9;
   localparam int DIV_STEPS   = 40;  // one quotient bit per step
   localparam int DIV_CNT_W   = 6;

   localparam logic [POP_SIZE_W-1:0] POP_SIZE_RESET = 9'd2;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_STATS  = 2'd1;
   localparam logic [1:0] OP_SELECT = 2'd2;

   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       entry_index;
      logic [FIT_W-1:0] fitness_value;
      logic [31:0]      random_fraction;
   } req_type;

   typedef struct packed {
      logic [7:0]       selected_index;
      logic [FIT_W-1:0] min_fitness;
      logic [FIT_W-1:0] max_fitness;
      logic [FIT_W-1:0] avg_fitness;
      logic [SUM_W-1:0] sum_fitness;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_IND,
      ST_WALK,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

// File: rtl/fitness_roulette_selector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fitness_roulette_selector: fitness-proportional (roulette wheel) selection
// Fitness table with write, stats (min/max/sum/avg) and select operations.
// ----------------------------------------------------------------------------
//
//  channel | ports               | dir | payload
//  --------+---------------------+-----+-------------------------------------
//  req     | req_valid/req_ready | in  | req_type: op, entry, value, fraction
//  rsp     | rsp_valid/rsp_ready | out | rsp_type: index, min, max, avg, sum
//  csr     | csr_wr_en           | in  | population_size, 9 bits, no wait
//
//  One item in flight. Write and unused op go straight from accept to the finish state.
//  Select: indicator multiply, then a walk with one table read per cycle.
//  Stats: one table read per cycle, then 40 divider steps.
//  n is population_size clamped to 2..POP_MAX. The table read port sets the walk.
//  Reset is synchronous; the table is not cleared: the user must write an entry before it is read,
//  and the block does not enforce this. A result held in rsp_data stalls only the finish of the
//  next item, not its accept.
//
module fitness_roulette_selector #(
   parameter int POP_MAX = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire frs_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output frs_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [frs_pkg::POP_SIZE_W-1:0] csr_wr_data
);

   localparam int ADDR_W = (POP_MAX > 2) ? $clog2(POP_MAX) : 1;
   localparam int CNT_W  = $clog2(POP_MAX + 1);
   localparam int EXT_W  = (ADDR_W > 8) ? ADDR_W : 8;
   localparam int RUN_W  = (frs_pkg::FIT_W + ADDR_W > frs_pkg::IND_W) ?
                           frs_pkg::FIT_W + ADDR_W : frs_pkg::IND_W;

   // control
   frs_pkg::state_type state_ff, state_in;
   logic [frs_pkg::POP_SIZE_W-1:0] pop_size_ff;
   logic                           op_stats_ff;
   logic [CNT_W-1:0]               n_ff;
   logic [CNT_W-1:0]               n_calc;
   logic [CNT_W-1:0]               issue_ff;
   logic                           rd_vld_ff;
   logic [ADDR_W-1:0]              rd_idx_ff;
   logic                           div_start_ff;
   logic                           rsp_valid_ff;
   logic [frs_pkg::SUM_W-1:0]      total_fitness_ff;

   // datapath
   logic [63:0]                    prod_lo_ff;
   logic [frs_pkg::SUM_W-1:0]      prod_hi_ff;
   logic [RUN_W-1:0]               ind_ff;
   logic [RUN_W-1:0]               run_ff;
   logic [frs_pkg::SUM_W-1:0]      sum_ff;
   logic [frs_pkg::FIT_W-1:0]      min_ff;
   logic [frs_pkg::FIT_W-1:0]      max_ff;
   frs_pkg::rsp_type               res_ff;
   frs_pkg::rsp_type               rsp_data_ff;

   logic                           accept;
   logic                           rd_en;
   logic                           wr_en;
   logic [EXT_W-1:0]               wr_idx_ext;
   logic [EXT_W-1:0]               pick_ext;
   logic [frs_pkg::FIT_W-1:0]      rd_data;
   logic                           last;
   logic [frs_pkg::SUM_W:0]        sum_wide;
   logic [frs_pkg::SUM_W-1:0]      sum_sat;
   logic [RUN_W-1:0]               run_next;
   logic                           hit;
   logic                           out_free;
   logic                           div_done;
   logic [frs_pkg::SUM_W-1:0]      div_quo;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // active population size
   always_comb begin
      if (pop_size_ff < frs_pkg::POP_SIZE_W'(2)) begin
         n_calc = CNT_W'(2);
      end else if (int'(pop_size_ff) > POP_MAX) begin
         n_calc = CNT_W'(POP_MAX);
      end else begin
         n_calc = CNT_W'(pop_size_ff);
      end
   end

   // table writes only happen in idle and reads only in the walk, so the
   // sequencing itself keeps read and write of an entry apart
   assign wr_idx_ext = EXT_W'(req_data.entry_index);
   assign wr_en      = accept && (req_data.op == frs_pkg::OP_WRITE) &&
                       (int'(req_data.entry_index) < POP_MAX);

   frs_table #(
      .DEPTH  (POP_MAX),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx_ext[ADDR_W-1:0]),
      .wr_data (req_data.fitness_value),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   frs_divider #(
      .DIV_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_ff),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // walk step: accumulate the entry that arrives this cycle
   assign last     = (CNT_W'(rd_idx_ff) == n_ff - 1'b1);
   assign sum_wide = {1'b0, sum_ff} + (frs_pkg::SUM_W + 1)'(rd_data);
   assign sum_sat  = sum_wide[frs_pkg::SUM_W] ? '1 : sum_wide[frs_pkg::SUM_W-1:0];
   assign run_next = run_ff + RUN_W'(rd_data);
   assign hit      = (run_next >= ind_ff);
   assign pick_ext = EXT_W'(rd_idx_ff);

   // next state and handshake
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      unique case (state_ff)
         frs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_data.op)
                  frs_pkg::OP_STATS:  state_in = frs_pkg::ST_WALK;
                  frs_pkg::OP_SELECT: state_in = frs_pkg::ST_IND;
                  default:            state_in = frs_pkg::ST_FINISH;
               endcase
            end
         end
         frs_pkg::ST_IND: begin
            state_in = frs_pkg::ST_WALK;
         end
         frs_pkg::ST_WALK: begin
            rd_en = (issue_ff < n_ff);
            if (rd_vld_ff) begin
               if (op_stats_ff) begin
                  if (last) begin
                     state_in = frs_pkg::ST_DIV;
                  end
               end else if (hit || last) begin
                  state_in = frs_pkg::ST_FINISH;
               end
            end
         end
         frs_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = frs_pkg::ST_FINISH;
            end
         end
         frs_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = frs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= frs_pkg::ST_IDLE;
         pop_size_ff      <= frs_pkg::POP_SIZE_RESET;
         rd_vld_ff        <= 1'b0;
         div_start_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         total_fitness_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_en;
         div_start_ff <= (state_ff == frs_pkg::ST_WALK) && rd_vld_ff &&
                         op_stats_ff && last;
         if (csr_wr_en) begin
            pop_size_ff <= csr_wr_data;
         end
         if ((state_ff == frs_pkg::ST_DIV) && div_done) begin
            total_fitness_ff <= sum_ff;
         end
         if ((state_ff == frs_pkg::ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff      <= '0;
         op_stats_ff <= (req_data.op == frs_pkg::OP_STATS);
         n_ff        <= n_calc;
         issue_ff    <= '0;
         sum_ff      <= '0;
         run_ff      <= '0;
         // indicator = frac * total >> 32, split at bit 32 of the total
         prod_lo_ff  <= 64'(req_data.random_fraction) * 64'(total_fitness_ff[31:0]);
         prod_hi_ff  <= frs_pkg::SUM_W'(req_data.random_fraction) *
                        frs_pkg::SUM_W'(total_fitness_ff[frs_pkg::SUM_W-1:32]);
      end
      if (state_ff == frs_pkg::ST_IND) begin
         ind_ff <= RUN_W'(prod_hi_ff) + RUN_W'(prod_lo_ff[63:32]);
      end
      if (rd_en) begin
         issue_ff <= issue_ff + 1'b1;
      end
      rd_idx_ff <= issue_ff[ADDR_W-1:0];
      if ((state_ff == frs_pkg::ST_WALK) && rd_vld_ff) begin
         if (op_stats_ff) begin
            sum_ff <= sum_sat;
            if (rd_idx_ff == '0) begin
               min_ff <= rd_data;
               max_ff <= rd_data;
            end else begin
               if (rd_data < min_ff) min_ff <= rd_data;
               if (rd_data > max_ff) max_ff <= rd_data;
            end
         end else begin
            run_ff <= run_next;
            // on the last entry without a hit, the last index is the pick
            res_ff.selected_index <= pick_ext[7:0];
         end
      end
      if ((state_ff == frs_pkg::ST_DIV) && div_done) begin
         res_ff.min_fitness <= min_ff;
         res_ff.max_fitness <= max_ff;
         res_ff.sum_fitness <= sum_ff;
         res_ff.avg_fitness <= (div_quo[frs_pkg::SUM_W-1:32] != '0) ?
                               '1 : div_quo[31:0];
      end
      if ((state_ff == frs_pkg::ST_FINISH) && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // divider finishes only while the controller waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == frs_pkg::ST_DIV))
      else $error("divider done outside the divide state");

   // walk never reads beyond the active population
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (CNT_W'(rd_idx_ff) < n_ff))
      else $error("table read beyond the active population");

   // kept sum only moves at the end of a stats pass
   a_total_only_after_div: assert property (@(posedge clock) disable iff (reset)
      (total_fitness_ff != $past(total_fitness_ff)) |->
         ($past(state_ff) == frs_pkg::ST_DIV || $past(reset)))
      else $error("kept sum changed outside a stats pass");

   // a held result blocks the finish of the next item
   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == frs_pkg::ST_FINISH) && rsp_valid_ff && !rsp_ready |=>
         (state_ff == frs_pkg::ST_FINISH))
      else $error("result overwritten while still held");

endmodule
`default_nettype wire

// File: rtl/frs_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_table: fitness table
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module frs_table #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [frs_pkg::FIT_W-1:0] wr_data,
   input  wire logic                     rd_en,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output logic      [frs_pkg::FIT_W-1:0] rd_data
);

   logic [frs_pkg::FIT_W-1:0] mem_ff [DEPTH];
   logic [frs_pkg::FIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/frs_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_divider: restoring divider for the stats average
// 40-bit dividend by a narrow divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frs_divider #(
   parameter int DIV_W = 9
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [frs_pkg::SUM_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]          divisor,
   output logic                           done,
   output logic      [frs_pkg::SUM_W-1:0] quotient
);

   logic [frs_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [frs_pkg::DIV_CNT_W-1:0] cnt_in;
   logic                          done_ff;
   logic [DIV_W-1:0]              rem_ff;
   logic [frs_pkg::SUM_W-1:0]     quo_ff;
   logic [DIV_W:0]                trial;
   logic [DIV_W:0]                diff;
   logic                          fits;
   logic                          busy;

   assign busy  = (cnt_ff != '0);
   assign trial = {rem_ff, quo_ff[frs_pkg::SUM_W-1]};
   assign fits  = (trial >= {1'b0, divisor});
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      cnt_in = cnt_ff;
      if (start) begin
         cnt_in = frs_pkg::DIV_CNT_W'(frs_pkg::DIV_STEPS);
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= (cnt_ff == frs_pkg::DIV_CNT_W'(1));
      end
   end

   // remainder stays below the divisor, so its low DIV_W bits hold it
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy) begin
         rem_ff <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_ff <= {quo_ff[frs_pkg::SUM_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// File: sim/frs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_checker: result checker for the fitness roulette selector
// Watches both channels and the population_size writes, keeps its own fitness
// table and kept sum, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module frs_checker #(
   parameter int POP_MAX = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire frs_pkg::req_type               req_data,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire frs_pkg::rsp_type               rsp_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [frs_pkg::POP_SIZE_W-1:0] csr_wr_data,
   output int                                  fail_count,
   output int                                  pending_count
);

   localparam logic [63:0] SUM_CAP      = 64'hFF_FFFF_FFFF;
   localparam logic [63:0] AVG_CAP      = 64'hFFFF_FFFF;
   localparam int          REPORT_LIMIT = 10;

   logic [frs_pkg::FIT_W-1:0]      fit_table [POP_MAX];
   logic [frs_pkg::SUM_W-1:0]      kept_sum;
   logic [frs_pkg::POP_SIZE_W-1:0] pop_size;
   frs_pkg::rsp_type               outstanding_results [$];
   int                             mismatches = 0;

   // Entries in use: size 0 and 1 act as 2, anything past the table as POP_MAX.
   function automatic int entries_in_use();
      if (pop_size < 2) return 2;
      if (pop_size > POP_MAX) return POP_MAX;
      return int'(pop_size);
   endfunction

   // Applies one item to the local table and returns the result it causes.
   function automatic frs_pkg::rsp_type apply_request(frs_pkg::req_type item);
      frs_pkg::rsp_type          res;
      int                        n;
      int                        i;
      logic [63:0]               acc;
      logic [63:0]               avg;
      logic [63:0]               frac;
      logic [63:0]               target;
      logic [frs_pkg::FIT_W-1:0] lo_fit;
      logic [frs_pkg::FIT_W-1:0] hi_fit;
      bit                        found;
      res = '0;
      n   = entries_in_use();
      case (item.op)
         frs_pkg::OP_WRITE: begin
            if (item.entry_index < POP_MAX) fit_table[item.entry_index] = item.fitness_value;
         end
         frs_pkg::OP_STATS: begin
            acc    = '0;
            lo_fit = fit_table[0];
            hi_fit = fit_table[0];
            for (i = 0; i < n; i++) begin
               acc = acc + 64'(fit_table[i]);
               if (acc > SUM_CAP) acc = SUM_CAP;
               if (fit_table[i] < lo_fit) lo_fit = fit_table[i];
               if (fit_table[i] > hi_fit) hi_fit = fit_table[i];
            end
            kept_sum = acc[frs_pkg::SUM_W-1:0];
            avg      = acc / 64'(n);
            if (avg > AVG_CAP) avg = AVG_CAP;
            res.min_fitness = lo_fit;
            res.max_fitness = hi_fit;
            res.avg_fitness = avg[frs_pkg::FIT_W-1:0];
            res.sum_fitness = kept_sum;
         end
         frs_pkg::OP_SELECT: begin
            // indicator = fraction * kept sum >> 32, split at bit 32 of the sum
            frac   = {32'd0, item.random_fraction};
            target = frac * {56'd0, kept_sum[39:32]}
                   + ((frac * {32'd0, kept_sum[31:0]}) >> 32);
            acc    = '0;
            found  = 1'b0;
            res.selected_index = 8'(n - 1);
            for (i = 0; i < n && !found; i++) begin
               acc = acc + 64'(fit_table[i]);
               if (acc >= target) begin
                  res.selected_index = 8'(i);
                  found = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      frs_pkg::rsp_type want;
      if (reset) begin
         outstanding_results.delete();
         kept_sum = '0;
         pop_size = frs_pkg::POP_SIZE_RESET;
      end else begin
         if (csr_wr_en) pop_size = csr_wr_data;
         // results first: an item accepted at this edge cannot answer at it
         if (rsp_valid && rsp_ready) begin
            if (outstanding_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result %0h", $time, rsp_data);
            end else begin
               want = outstanding_results.pop_front();
               check_field("selected_index", 64'(want.selected_index),
                           64'(rsp_data.selected_index));
               check_field("min_fitness", 64'(want.min_fitness),
                           64'(rsp_data.min_fitness));
               check_field("max_fitness", 64'(want.max_fitness),
                           64'(rsp_data.max_fitness));
               check_field("avg_fitness", 64'(want.avg_fitness),
                           64'(rsp_data.avg_fitness));
               check_field("sum_fitness", 64'(want.sum_fitness),
                           64'(rsp_data.sum_fitness));
            end
         end
         if (req_valid && req_ready) outstanding_results.push_back(apply_request(req_data));
      end
      fail_count    <= mismatches;
      pending_count <= outstanding_results.size();
   end

endmodule
`default_nettype wire

// File: sim/fitness_roulette_selector_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fitness_roulette_selector_tb: testbench top of the fitness roulette selector
// Drives writes, stats passes and selects over many population sizes with
// random idling and back-pressure; frs_checker predicts and compares results.
// ----------------------------------------------------------------------------
module fitness_roulette_selector_tb;

   localparam int         POP_MAX     = 256;
   localparam int         HOLD_CYCLES = 600;   // one long receiver hold-off
   localparam int         STALL_LIMIT = 5000;  // cycles with no item moving
   localparam int         ITEM_TARGET = 1100;
   localparam int         TAIL_CYCLES = 320;   // > slowest stats pass at n = 256
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_ready;
   frs_pkg::req_type               req_data    = '0;
   logic                           rsp_valid;
   logic                           rsp_ready   = 1'b0;
   frs_pkg::rsp_type               rsp_data;
   logic                           csr_wr_en   = 1'b0;
   logic [frs_pkg::POP_SIZE_W-1:0] csr_wr_data = '0;

   int fail_count;
   int pending_count;

   // stimulus-side bookkeeping
   logic calm        = 1'b0;  // no idling on either side while set
   logic hold_arm    = 1'b0;  // starts the long receiver hold-off
   int   hold_count  = 0;
   int   idle_cycles = 0;
   int   items_sent  = 0;
   int   active_n    = 2;     // clamped population_size as the block sees it
   bit   written [POP_MAX];   // entries written so far; only these get read

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fitness_roulette_selector #(
      .POP_MAX     (POP_MAX)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   frs_checker #(
      .POP_MAX       (POP_MAX)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Receiver: ~16% random stalls, none in calm phases, and once a long
   // hold-off so the block fills up and pushes back on the sender.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_arm && hold_count < HOLD_CYCLES) begin
         rsp_ready <= 1'b0;
         hold_count++;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 16);
      end
   end

   // Watchdog: a run that stops moving items is a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Mostly random words, with the extremes and sparse patterns mixed in.
   function automatic logic [31:0] rand_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return 32'($urandom_range(65535));
         3:       return 32'h1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   function automatic frs_pkg::req_type make_req(logic [1:0] op, logic [7:0] idx,
                                                 logic [31:0] val, logic [31:0] frac);
      frs_pkg::req_type item;
      item.op              = op;
      item.entry_index     = idx;
      item.fitness_value   = val;
      item.random_fraction = frac;
      return item;
   endfunction

   // Offers one item and returns at the edge that accepts it. Valid stays
   // high into the next item unless an idle gap is drawn.
   task automatic offer(input frs_pkg::req_type item);
      while (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      items_sent++;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // Unused fields carry random bits so every input bit toggles.
   task automatic do_write(input logic [7:0] idx, input logic [31:0] val);
      written[idx] = 1'b1;
      offer(make_req(frs_pkg::OP_WRITE, idx, val, $urandom));
   endtask

   task automatic do_stats();
      offer(make_req(frs_pkg::OP_STATS, 8'($urandom), $urandom, $urandom));
   endtask

   task automatic do_select(input logic [31:0] frac);
      offer(make_req(frs_pkg::OP_SELECT, 8'($urandom), $urandom, frac));
   endtask

   // Sender pause: drop valid and wait until every result has come back.
   // pending_count is registered, hence the first wait.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // population_size is only written with the block idle.
   task automatic set_population(input logic [frs_pkg::POP_SIZE_W-1:0] size);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_n = (size < 2) ? 2 : (size > POP_MAX) ? POP_MAX : int'(size);
   endtask

   // Stats and select read every entry in use, so none may be unwritten.
   task automatic fill_unwritten();
      int i;
      for (i = 0; i < active_n; i++)
         if (!written[i]) do_write(8'(i), rand_word());
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) begin
         // mostly entries in use, sometimes anywhere in the table
         if ($urandom_range(3) == 0) do_write(8'($urandom_range(255)), rand_word());
         else do_write(8'($urandom_range(active_n - 1)), rand_word());
      end else if (pick < 50) begin
         do_stats();
      end else if (pick < 95) begin
         do_select(rand_word());
      end else begin
         offer(make_req(OP_UNUSED, 8'($urandom), $urandom, $urandom));
      end
   endtask

   initial begin
      int i;
      int phase;
      int count;
      logic [frs_pkg::POP_SIZE_W-1:0] size;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed part, size 2 after reset ---
      do_write(8'd0, '1);
      do_write(8'd1, '0);
      do_select('1);                            // zero kept sum: index 0
      offer(make_req(OP_UNUSED, '1, '1, '1));   // unused op, all-zero result
      do_stats();                               // min 0, max all ones
      do_select('0);
      do_select('1);
      do_select(32'h8000_0000);
      do_write(8'd1, 32'h0001_0000);            // table now differs from kept sum
      do_select('1);                            // stale sum still in use
      do_write(8'd255, '1);                     // writes outside the size in use
      do_write(8'd128, '0);
      offer(make_req(OP_UNUSED, '0, '0, '0));

      set_population(9'd0);                     // acts as 2
      do_stats();
      do_select(32'd1);
      set_population(9'd1);                     // acts as 2
      do_stats();

      // full table of the largest value: biggest sum and average
      set_population(9'd511);                   // acts as POP_MAX
      for (i = 0; i < POP_MAX; i++) do_write(8'(i), '1);
      do_stats();
      do_select('1);                            // lands on the last entry
      do_select('0);
      do_select(32'h8000_0000);

      // --- random phases, each at its own population size ---
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         phase++;
         case ($urandom_range(9))
            0:       size = 9'($urandom_range(1));
            1:       size = 9'($urandom_range(257, 511));
            2:       size = 9'd256;
            3, 4:    size = 9'($urandom_range(2, 256));
            default: size = 9'($urandom_range(2, 12));
         endcase
         set_population(size);
         fill_unwritten();
         calm <= (phase % 6 == 5);
         // receiver stalls for a long stretch while items keep coming
         if (phase == 3) hold_arm <= 1'b1;
         count = $urandom_range(30, 70);
         repeat (count) random_item();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
